### hdl/open_addressing_hash_set_defines.svh
// Assertion shorthands for the hash set checks
`ifndef OPEN_ADDRESSING_HASH_SET_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_SET_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define OHS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash set check failed");

// next-cycle implication, quiet while reset is held
`define OHS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash set check failed");

`endif

### hdl/ohs_pkg.sv
package ohs_pkg;

  // default sizes and fixed field widths
  localparam int TableSizeDef = 8;
  localparam int KeyWidthDef  = 32;
  localparam int FuncW        = 2;
  localparam int KeyInW       = 32;
  localparam int StatusW      = 2;
  localparam int SlotW        = 3;
  localparam int DigitW       = 4;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_USED = 2'd1,
    MARK_GONE = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  // microprogram addresses
  typedef enum logic [2:0] {
    UP_CLR  = 3'd0,
    UP_IDLE = 3'd1,
    UP_HOME = 3'd2,
    UP_EVAL = 3'd3,
    UP_EMIT = 3'd4
  } upc_e;

  // jump conditions; when false the sequencer holds its step
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_CLR_LAST  = 3'd1,
    C_ACCEPT    = 3'd2,
    C_HOME_DONE = 3'd3,
    C_PROBE_END = 3'd4,
    C_OUT_FREE  = 3'd5
  } cond_e;

  typedef struct packed {
    logic rdy;
    logic clr;
    logic home;
    logic eval;
    logic emit;
  } ohs_ctrl_t;

  typedef struct packed {
    logic accept;
    logic clr_last;
    logic home_done;
    logic probe_end;
    logic out_free;
  } ohs_cond_t;

  typedef struct packed {
    ohs_ctrl_t ctrl;
    cond_e     cond;
    upc_e      target;
  } uword_t;

  // control store
  function automatic uword_t ucode(upc_e pc);
    uword_t w;
    w = '0;
    case (pc)
      UP_CLR: begin
        w.ctrl.clr = 1'b1;
        w.cond     = C_CLR_LAST;
        w.target   = UP_IDLE;
      end
      UP_IDLE: begin
        w.ctrl.rdy = 1'b1;
        w.cond     = C_ACCEPT;
        w.target   = UP_HOME;
      end
      UP_HOME: begin
        w.ctrl.home = 1'b1;
        w.cond      = C_HOME_DONE;
        w.target    = UP_EVAL;
      end
      UP_EVAL: begin
        w.ctrl.eval = 1'b1;
        w.cond      = C_PROBE_END;
        w.target    = UP_EMIT;
      end
      UP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = C_OUT_FREE;
        w.target    = UP_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = UP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### hdl/ohs_if.sv
// input item channel
interface ohs_in_if;
  logic                         valid;
  logic                         ready;
  logic [ohs_pkg::FuncW-1:0]    func;
  logic [ohs_pkg::KeyInW-1:0]   key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

// result item channel
interface ohs_out_if;
  logic                         valid;
  logic                         ready;
  logic [ohs_pkg::StatusW-1:0]  status;
  logic [ohs_pkg::SlotW-1:0]    slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

### hdl/ohs_seq.sv
module ohs_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ohs_pkg::ohs_cond_t cond_i,
  output ohs_pkg::ohs_ctrl_t ctrl_o
);

  ohs_pkg::upc_e   upc_q, upc_d;
  ohs_pkg::uword_t uw;
  logic            take;

  // step counter; reset starts the clearing routine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ohs_pkg::UP_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  // fetch, condition select, jump
  always_comb begin
    uw = ohs_pkg::ucode(upc_q);
    case (uw.cond)
      ohs_pkg::C_ALWAYS:    take = 1'b1;
      ohs_pkg::C_CLR_LAST:  take = cond_i.clr_last;
      ohs_pkg::C_ACCEPT:    take = cond_i.accept;
      ohs_pkg::C_HOME_DONE: take = cond_i.home_done;
      ohs_pkg::C_PROBE_END: take = cond_i.probe_end;
      ohs_pkg::C_OUT_FREE:  take = cond_i.out_free;
      default:              take = 1'b1;
    endcase
    upc_d  = take ? uw.target : upc_q;
    ctrl_o = uw.ctrl;
  end

endmodule

### hdl/open_addressing_hash_set.sv
// Steps: an accepted item passes the home, probe and emit steps; the probe step reads P slots, where P
//   (1 to TABLE_SIZE) is the number of slots probed, one per cycle through the table RAM.
// For sizes other than a power of two the home step also reduces the key, 4 bits a cycle.
// Items: one in flight; a new item is taken only after the last one's emit step. A waiting
//   result holds back only the emit step of the next item, not its acceptance or probe.
// Reset: asynchronous, active low; then a clearing pass marks every slot free, with in ready low.
module open_addressing_hash_set #(
  parameter int TABLE_SIZE = ohs_pkg::TableSizeDef,
  parameter int KEY_WIDTH  = ohs_pkg::KeyWidthDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  ohs_in_if.sink    in_i,
  ohs_out_if.source out_o
);

  localparam int  PW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int  SW     = $clog2(TABLE_SIZE + 1);
  localparam bit  POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam int  HW     = (KEY_WIDTH > PW) ? KEY_WIDTH : PW;
  localparam int  DIGITS = (HW + ohs_pkg::DigitW - 1) / ohs_pkg::DigitW;
  localparam int  DW     = DIGITS * ohs_pkg::DigitW;
  localparam int  CW     = $clog2(DIGITS + 1);
  localparam int  EW     = KEY_WIDTH + 2;
  localparam int  TW     = PW + ohs_pkg::DigitW;

  ohs_pkg::ohs_ctrl_t ctrl;
  ohs_pkg::ohs_cond_t cond;

  logic                          accept;
  logic [KEY_WIDTH-1:0]          key_ext;
  logic [ohs_pkg::FuncW-1:0]     func_q;
  logic [KEY_WIDTH-1:0]          key_q;
  logic [DW-1:0]                 sh_q;
  logic [CW-1:0]                 cnt_q;
  logic [PW-1:0]                 r_q;
  logic [PW-1:0]                 p_q;
  logic [SW-1:0]                 stp_q;
  logic [TW-1:0]                 acc;
  logic [PW-1:0]                 r_red;
  logic [PW:0]                   sum;
  logic [PW-1:0]                 p_nx;

  // table RAM: mark above key
  logic [EW-1:0]                 mem_q [TABLE_SIZE];
  logic [EW-1:0]                 rd_q;
  logic                          wr_en;
  logic [EW-1:0]                 wr_data;
  logic [PW-1:0]                 rd_addr;

  logic [1:0]                    mark;
  logic [KEY_WIDTH-1:0]          skey;
  logic                          is_ins, is_find, is_rem, is_bad, last;
  logic                          hit_ins, hit_find, stop_free;

  logic [ohs_pkg::StatusW-1:0]   res_status_q;
  logic [PW-1:0]                 res_slot_q;
  logic                          out_valid_q;
  logic [ohs_pkg::StatusW-1:0]   out_status_q;
  logic [ohs_pkg::SlotW-1:0]     out_slot_q;

  ohs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  assign in_i.ready = ctrl.rdy;
  assign accept     = in_i.valid & ctrl.rdy;
  assign key_ext    = KEY_WIDTH'(in_i.key);

  // one digit of the home reduction: fold in 4 key bits, bring back below the size
  always_comb begin
    acc = {r_q, sh_q[DW-1 -: ohs_pkg::DigitW]};
    for (int i = ohs_pkg::DigitW - 1; i >= 0; i--) begin
      if (acc >= (TW'(TABLE_SIZE) << i)) begin
        acc = acc - (TW'(TABLE_SIZE) << i);
      end
    end
    r_red = PW'(acc);
  end

  // next probe slot, triangular step
  always_comb begin
    sum  = (PW+1)'(p_q) + (PW+1)'(stp_q);
    p_nx = (sum >= (PW+1)'(TABLE_SIZE)) ? PW'(sum - (PW+1)'(TABLE_SIZE)) : PW'(sum);
  end

  // probe evaluation on the slot read last cycle
  always_comb begin
    mark      = rd_q[EW-1:KEY_WIDTH];
    skey      = rd_q[KEY_WIDTH-1:0];
    is_ins    = func_q == ohs_pkg::FUNC_INSERT;
    is_rem    = func_q == ohs_pkg::FUNC_REMOVE;
    is_find   = (func_q == ohs_pkg::FUNC_SEARCH) | is_rem;
    is_bad    = ~is_ins & ~is_find;
    last      = stp_q == SW'(TABLE_SIZE);
    hit_ins   = is_ins & (mark != ohs_pkg::MARK_USED);
    hit_find  = is_find & (mark == ohs_pkg::MARK_USED) & (skey == key_q);
    stop_free = is_find & (mark == ohs_pkg::MARK_FREE);
  end

  always_comb begin
    cond.accept    = accept;
    cond.clr_last  = p_q == PW'(TABLE_SIZE - 1);
    cond.home_done = cnt_q == '0;
    cond.probe_end = hit_ins | hit_find | stop_free | is_bad | last;
    cond.out_free  = ~out_valid_q | out_o.ready;
  end

  // RAM write and read port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_data = {ohs_pkg::MARK_FREE, KEY_WIDTH'(0)};
    if (ctrl.clr) begin
      wr_en = 1'b1;
    end else if (ctrl.eval && hit_ins) begin
      wr_en   = 1'b1;
      wr_data = {ohs_pkg::MARK_USED, key_q};
    end else if (ctrl.eval && hit_find && is_rem) begin
      wr_en   = 1'b1;
      wr_data = {ohs_pkg::MARK_GONE, skey};
    end
    rd_addr = ctrl.home ? r_q : p_nx;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[p_q] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q   <= '0;
      cnt_q <= '0;
    end else begin
      if (ctrl.clr) begin
        p_q <= PW'(p_q + 1'b1);
      end else if (ctrl.home && cond.home_done) begin
        p_q <= r_q;
      end else if (ctrl.eval && !cond.probe_end) begin
        p_q <= p_nx;
      end
      if (accept) begin
        cnt_q <= POW2 ? '0 : CW'(DIGITS);
      end else if (ctrl.home && !cond.home_done) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // item payload and reduction registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      key_q  <= key_ext;
      sh_q   <= DW'(key_ext);
      r_q    <= POW2 ? PW'(key_ext) : '0;
    end else if (ctrl.home && !cond.home_done) begin
      r_q  <= r_red;
      sh_q <= sh_q << ohs_pkg::DigitW;
    end
    if (ctrl.home && cond.home_done) begin
      stp_q <= SW'(1);
    end else if (ctrl.eval && !cond.probe_end) begin
      stp_q <= stp_q + 1'b1;
    end
    if (ctrl.eval && cond.probe_end) begin
      if (hit_ins || hit_find) begin
        res_status_q <= ohs_pkg::ST_OK;
        res_slot_q   <= p_q;
      end else begin
        res_status_q <= is_ins ? ohs_pkg::ST_FULL : ohs_pkg::ST_ABSENT;
        res_slot_q   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && cond.out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && cond.out_free) begin
      out_status_q <= res_status_q;
      out_slot_q   <= ohs_pkg::SlotW'(res_slot_q);
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.slot   = out_slot_q;

endmodule

### hdl/ohs_checker.sv
`include "open_addressing_hash_set_defines.svh"

module ohs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ohs_pkg::StatusW-1:0] out_status_i,
  input logic [ohs_pkg::SlotW-1:0]   out_slot_i
);

  // a failed operation reports slot zero
  `OHS_ASSERT_IMP(a_fail_slot_zero, clk_i, rst_ni, out_valid_i && (out_status_i != ohs_pkg::ST_OK), out_slot_i == '0)

  // one item at a time: ready drops right after an accept
  `OHS_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a new result only comes while no item is being taken
  `OHS_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

  // a stalled result stays offered
  `OHS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind open_addressing_hash_set ohs_checker u_ohs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_slot_i   (out_o.slot)
);
